// File: src/oli_pkg.sv
// ----------------------------------------------------------------------------
// oli_pkg: shared types and constants for the ordered list insert block
// Sizes of the cell chain, command and status codes, and the cell control
// word.
// ----------------------------------------------------------------------------
package oli_pkg;

    // Number of cells in the chain (2 to 64)
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;

    // Command carried on the slave-side tuser
    typedef enum logic [1:0] {
        CMD_HEAD    = 2'd0,
        CMD_TAIL    = 2'd1,
        CMD_ORDERED = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    // Result kind carried on the master-side tuser
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_READ     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // Per-cell load control
    typedef struct packed {
        logic take_new;   // load the inserted value
        logic take_left;  // load the left neighbor's value (shift right)
    } cell_ctrl_t;

endpackage

// File: src/ordered_list_insert_top.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_top: bounded ordered list of signed 32-bit values
// Inserts at head, tail or in order into a chain of cells, and streams the
// whole list out on request.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                          | tuser       | tlast
//  s_axis   | in  | new_value[31:0]                | cmd[1:0]    | -
//  m_axis   | out | entry_value[31:0], position    | status[1:0] | last
//           |     | [37:32], zero pad [39:38]      |             |
//
// On an insert every cell compares itself with the incoming value, and the
// chain shifts right of the insert point in the same edge.
// A read-out loads the entries in order through the single read mux over
// the cells, holding while the master side stalls; the input stays stalled
// until the last entry is loaded into the output register.
// Reset (rst_n, asynchronous) empties the list; cell contents are not reset.
// A stalled master side holds the output register and blocks new transfers.
// ----------------------------------------------------------------------------
module ordered_list_insert_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] new_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] entry_value, [37:32] position
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);

    localparam int CAP   = oli_pkg::CAPACITY;
    localparam int IDX_W = oli_pkg::IDX_W;
    localparam int CNT_W = oli_pkg::CNT_W;
    localparam int VAL_W = oli_pkg::VALUE_W;
    localparam int POS_W = oli_pkg::POS_W;

    // Control registers
    logic              m_tvalid_reg, m_tvalid_next;
    logic              rd_active_reg, rd_active_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;

    // Output payload registers
    oli_pkg::status_t        status_reg, status_next;
    logic signed [VAL_W-1:0] value_reg, value_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic                    last_reg, last_next;

    // Datapath
    oli_pkg::cmd_t           cmd;
    logic signed [VAL_W-1:0] new_value;
    logic                    accept;
    logic                    out_free;
    logic                    full;
    logic                    do_ins;
    logic [CNT_W-1:0]        ord_pos;
    logic [CNT_W-1:0]        ins_pos;
    logic                    found;
    logic                    rd_last;
    logic signed [VAL_W-1:0] rd_value;

    logic signed [VAL_W-1:0] cell_value [CAP];
    logic                    cell_ge    [CAP];
    oli_pkg::cell_ctrl_t     cell_ctrl  [CAP];

    assign cmd       = oli_pkg::cmd_t'(s_axis_tuser);
    assign new_value = s_axis_tdata;
    assign out_free  = !m_tvalid_reg || m_axis_tready;
    assign s_axis_tready = !rd_active_reg && out_free;
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign full      = (count_reg == CNT_W'(CAP));
    assign do_ins    = accept && (cmd != oli_pkg::CMD_READ) && !full;

    // Find the ordered insert point from the cell compare flags
    always_comb
    begin
        ord_pos = count_reg;
        found   = 1'b0;
        for (int i = 1; i < CAP; i++)
        begin
            if (!found && (CNT_W'(i) < count_reg) && cell_ge[i])
            begin
                ord_pos = CNT_W'(i);
                found   = 1'b1;
            end
        end
        // Go to the front only when the list is empty or the first entry is strictly above the value
        if ((count_reg == '0) || (cell_ge[0] && (cell_value[0] != new_value)))
        begin
            ord_pos = '0;
        end
    end

    // Pick the insert point for the command
    always_comb
    begin
        unique case (cmd)
            oli_pkg::CMD_HEAD:    ins_pos = '0;
            oli_pkg::CMD_TAIL:    ins_pos = count_reg;
            oli_pkg::CMD_ORDERED: ins_pos = ord_pos;
            default:              ins_pos = '0;
        endcase
    end

    // Cell chain
    genvar g;
    generate
        for (g = 0; g < CAP; g++)
        begin : g_cell
            logic signed [VAL_W-1:0] left_value;

            if (g == 0)
            begin : g_first
                assign left_value = new_value;
            end
            else
            begin : g_rest
                assign left_value = cell_value[g-1];
            end

            assign cell_ctrl[g].take_new  = do_ins && (CNT_W'(g) == ins_pos);
            assign cell_ctrl[g].take_left = do_ins && (CNT_W'(g) > ins_pos);

            oli_cell u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl[g]),
                .new_value  (new_value),
                .left_value (left_value),
                .value      (cell_value[g]),
                .ge         (cell_ge[g])
            );
        end
    endgenerate

    // Read-out select
    assign rd_value = cell_value[rd_idx_reg];
    assign rd_last  = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);

    // Next-state and output register load
    always_comb
    begin
        m_tvalid_next  = m_tvalid_reg && !m_axis_tready;
        rd_active_next = rd_active_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        status_next    = status_reg;
        value_next     = value_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;

        if (accept)
        begin
            if (cmd == oli_pkg::CMD_READ)
            begin
                if (count_reg == '0)
                begin
                    m_tvalid_next = 1'b1;
                    status_next   = oli_pkg::ST_EMPTY;
                    value_next    = '0;
                    pos_next      = '0;
                    last_next     = 1'b1;
                end
                else
                begin
                    rd_active_next = 1'b1;
                    rd_idx_next    = '0;
                end
            end
            else if (full)
            begin
                m_tvalid_next = 1'b1;
                status_next   = oli_pkg::ST_FULL;
                value_next    = new_value;
                pos_next      = '0;
                last_next     = 1'b1;
            end
            else
            begin
                m_tvalid_next = 1'b1;
                count_next    = count_reg + CNT_W'(1);
                status_next   = oli_pkg::ST_INSERTED;
                value_next    = new_value;
                pos_next      = POS_W'(ins_pos);
                last_next     = 1'b1;
            end
        end
        else if (rd_active_reg && out_free)
        begin
            m_tvalid_next = 1'b1;
            status_next   = oli_pkg::ST_READ;
            value_next    = rd_value;
            pos_next      = POS_W'(rd_idx_reg);
            last_next     = rd_last;
            rd_idx_next   = rd_idx_reg + IDX_W'(1);
            if (rd_last)
            begin
                rd_active_next = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg  <= 1'b0;
            rd_active_reg <= 1'b0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            m_tvalid_reg  <= m_tvalid_next;
            rd_active_reg <= rd_active_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
        end
    end

    // Output payload registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        pos_reg    <= pos_next;
        last_reg   <= last_next;
    end

    // Drive the master side
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {2'b00, pos_reg, value_reg};
    assign m_axis_tuser  = status_reg;
    assign m_axis_tlast  = last_reg;

endmodule

// File: src/oli_cell.sv
// ----------------------------------------------------------------------------
// oli_cell: one storage cell of the ordered list chain
// Holds one entry, shifts in its left neighbor or the inserted value, and
// compares its entry against the incoming value.
// ----------------------------------------------------------------------------
module oli_cell (
    input  logic                              clk,
    input  oli_pkg::cell_ctrl_t               ctrl,
    input  logic signed [oli_pkg::VALUE_W-1:0] new_value,
    input  logic signed [oli_pkg::VALUE_W-1:0] left_value,
    output logic signed [oli_pkg::VALUE_W-1:0] value,
    output logic                              ge
);

    logic signed [oli_pkg::VALUE_W-1:0] value_reg;
    logic signed [oli_pkg::VALUE_W-1:0] value_next;

    // Select the next entry: new value, neighbor, or hold
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.take_new)
        begin
            value_next = new_value;
        end
        else if (ctrl.take_left)
        begin
            value_next = left_value;
        end
    end

    // Hold the entry (payload, no reset)
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    // Flag entries at or above the incoming value
    assign ge    = (value_reg >= new_value);
    assign value = value_reg;

endmodule
